// File: sv/tpst_pkg.sv
// shared widths, latencies and sideband type for the two point similarity transform
package tpst_pkg;

  localparam int CRD_W   = 32;             // q24.8 coordinate
  localparam int DIF_W   = CRD_W + 1;      // difference of two coordinates
  localparam int PRD_W   = 2 * DIF_W;      // product of two differences
  localparam int SUM_W   = PRD_W + 1;      // dot or cross product
  localparam int MAG_W   = SUM_W - 1;      // magnitude of a dot or cross product
  localparam int SQ_W    = PRD_W;          // squared length of the source vector
  localparam int NUM_W   = MAG_W + 18;     // rounded dividend, magnitude shifted by 17
  localparam int DEN_W   = SQ_W + 1;       // twice the squared length
  localparam int QUO_W   = 32;             // quotient bits kept before saturation
  localparam int ACC_W   = CRD_W + DIF_W + 2;  // q.24 accumulator
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int BACK_LAT  = 4;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + BACK_LAT;

  typedef struct packed {
    logic                    deg;
    logic                    neg_a;
    logic                    neg_b;
    logic signed [CRD_W-1:0] ax;
    logic signed [CRD_W-1:0] ay;
    logic signed [DIF_W-1:0] dx;
    logic signed [DIF_W-1:0] dy;
  } tpst_side_t;

endpackage

// File: sv/tpst_front.sv
// front stages: differences, products, dot and cross sums, dividend and divisor
module tpst_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic signed [tpst_pkg::CRD_W-1:0] from_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] from_y,
  input  logic signed [tpst_pkg::CRD_W-1:0] to_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] to_y,
  input  logic signed [tpst_pkg::CRD_W-1:0] about_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] about_y,
  input  logic signed [tpst_pkg::CRD_W-1:0] point_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] point_y,
  output logic                              out_vld,
  output logic [tpst_pkg::NUM_W-1:0]        num_a,
  output logic [tpst_pkg::NUM_W-1:0]        num_b,
  output logic [tpst_pkg::DEN_W-1:0]        den,
  output tpst_pkg::tpst_side_t              side
);
  import tpst_pkg::*;

  logic [FRONT_LAT-1:0] vld;

  logic signed [DIF_W-1:0] vx1, vy1, wx1, wy1, dx1, dy1;
  logic signed [CRD_W-1:0] ax1, ay1;

  logic signed [PRD_W-1:0] pxx2, pyy2, pa1_2, pa2_2, pb1_2, pb2_2;
  logic signed [DIF_W-1:0] dx2, dy2;
  logic signed [CRD_W-1:0] ax2, ay2;

  logic [SQ_W-1:0]         d3;
  logic signed [SUM_W-1:0] na3, nb3;
  logic signed [DIF_W-1:0] dx3, dy3;
  logic signed [CRD_W-1:0] ax3, ay3;

  logic [SQ_W-1:0]  d4;
  logic [MAG_W-1:0] ma4, mb4;
  logic             neg_a4, neg_b4;
  logic signed [DIF_W-1:0] dx4, dy4;
  logic signed [CRD_W-1:0] ax4, ay4;

  logic signed [SUM_W-1:0] dd_sum;
  logic signed [SUM_W-1:0] na_neg, nb_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], in_vld};
    end
  end

  assign dd_sum = SUM_W'(pxx2) + SUM_W'(pyy2);
  assign na_neg = -na3;
  assign nb_neg = -nb3;

  always_ff @(posedge clk) begin
    // vectors relative to the pivot
    vx1 <= DIF_W'(from_x) - DIF_W'(about_x);
    vy1 <= DIF_W'(from_y) - DIF_W'(about_y);
    wx1 <= DIF_W'(to_x) - DIF_W'(about_x);
    wy1 <= DIF_W'(to_y) - DIF_W'(about_y);
    dx1 <= DIF_W'(point_x) - DIF_W'(about_x);
    dy1 <= DIF_W'(point_y) - DIF_W'(about_y);
    ax1 <= about_x;
    ay1 <= about_y;

    pxx2  <= vx1 * vx1;
    pyy2  <= vy1 * vy1;
    pa1_2 <= wx1 * vx1;
    pa2_2 <= wy1 * vy1;
    pb1_2 <= wy1 * vx1;
    pb2_2 <= wx1 * vy1;
    dx2 <= dx1;
    dy2 <= dy1;
    ax2 <= ax1;
    ay2 <= ay1;

    d3  <= dd_sum[SQ_W-1:0];
    na3 <= SUM_W'(pa1_2) + SUM_W'(pa2_2);
    nb3 <= SUM_W'(pb1_2) - SUM_W'(pb2_2);
    dx3 <= dx2;
    dy3 <= dy2;
    ax3 <= ax2;
    ay3 <= ay2;

    d4     <= d3;
    neg_a4 <= na3[SUM_W-1];
    neg_b4 <= nb3[SUM_W-1];
    ma4    <= na3[SUM_W-1] ? na_neg[MAG_W-1:0] : na3[MAG_W-1:0];
    mb4    <= nb3[SUM_W-1] ? nb_neg[MAG_W-1:0] : nb3[MAG_W-1:0];
    dx4 <= dx3;
    dy4 <= dy3;
    ax4 <= ax3;
    ay4 <= ay3;

    // round half away from zero: (|n| * 2^17 + d) / (2 d)
    num_a <= {ma4, 17'b0} + NUM_W'(d4);
    num_b <= {mb4, 17'b0} + NUM_W'(d4);
    den   <= {d4, 1'b0};
    side.deg   <= (d4 == '0);
    side.neg_a <= neg_a4;
    side.neg_b <= neg_b4;
    side.ax    <= ax4;
    side.ay    <= ay4;
    side.dx    <= dx4;
    side.dy    <= dy4;
  end

  assign out_vld = vld[FRONT_LAT-1];

endmodule

// File: sv/tpst_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module tpst_div (
  input  logic                       clk,
  input  logic [tpst_pkg::NUM_W-1:0] num,
  input  logic [tpst_pkg::DEN_W-1:0] den,
  output logic [tpst_pkg::QUO_W-1:0] quo,
  output logic                       ovf
);
  import tpst_pkg::*;

  localparam int CMP_W = NUM_W + QUO_W;

  logic [NUM_W-1:0] rem [0:QUO_W];
  logic [DEN_W-1:0] dd  [0:QUO_W];
  logic [QUO_W-1:0] qq  [0:QUO_W];
  logic             ov  [0:QUO_W];

  // quotient too wide for the kept bits
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dd[0]  <= den;
    qq[0]  <= '0;
    ov[0]  <= ({{QUO_W{1'b0}}, num} >= {{(NUM_W - DEN_W){1'b0}}, den, {QUO_W{1'b0}}});
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    localparam int B = QUO_W - k;
    logic [CMP_W:0]   diff;
    logic             take;
    logic [QUO_W-1:0] qn;

    always_comb begin
      diff = {1'b0, {QUO_W{1'b0}}, rem[k-1]}
           - ({1'b0, {(CMP_W - DEN_W){1'b0}}, dd[k-1]} << B);
      take = !diff[CMP_W];
      qn = qq[k-1];
      qn[B] = take;
    end

    always_ff @(posedge clk) begin
      rem[k] <= take ? diff[NUM_W-1:0] : rem[k-1];
      dd[k]  <= dd[k-1];
      qq[k]  <= qn;
      ov[k]  <= ov[k-1];
    end
  end

  assign quo = qq[QUO_W];
  assign ovf = ov[QUO_W];

endmodule

// File: sv/tpst_back.sv
// back stages: matrix saturation, translation and mapping, rounding to q24.8
module tpst_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  input  logic [tpst_pkg::QUO_W-1:0]        quo_a,
  input  logic                              ovf_a,
  input  logic [tpst_pkg::QUO_W-1:0]        quo_b,
  input  logic                              ovf_b,
  input  tpst_pkg::tpst_side_t              side,
  output logic                              done,
  output logic signed [tpst_pkg::CRD_W-1:0] m00,
  output logic signed [tpst_pkg::CRD_W-1:0] m01,
  output logic signed [tpst_pkg::CRD_W-1:0] m10,
  output logic signed [tpst_pkg::CRD_W-1:0] m11,
  output logic signed [tpst_pkg::CRD_W-1:0] shift_x,
  output logic signed [tpst_pkg::CRD_W-1:0] shift_y,
  output logic signed [tpst_pkg::CRD_W-1:0] mapped_x,
  output logic signed [tpst_pkg::CRD_W-1:0] mapped_y,
  output logic                              degenerate
);
  import tpst_pkg::*;

  localparam int MP_W = CRD_W + DIF_W;

  function automatic logic signed [CRD_W-1:0] sat_q(input logic neg, input logic of,
                                                    input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] lim;
    lim = {1'b1, {(QUO_W - 1){1'b0}}};
    if (neg) begin
      if (of || q > lim) return lim;
      return CRD_W'(-q);
    end
    if (of || q[QUO_W-1]) return ~lim;
    return q;
  endfunction

  // add half, arithmetic shift by 16, saturate
  function automatic logic signed [CRD_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0]    t;
    logic signed [ACC_W-17:0]   r;
    t = s + ACC_W'(32768);
    r = t[ACC_W-1:16];
    if (r[ACC_W-17:CRD_W-1] == '0 || r[ACC_W-17:CRD_W-1] == '1) return r[CRD_W-1:0];
    if (r[ACC_W-17]) return {1'b1, {(CRD_W - 1){1'b0}}};
    return {1'b0, {(CRD_W - 1){1'b1}}};
  endfunction

  logic [BACK_LAT-2:0] vld;

  logic signed [CRD_W-1:0] a1, b1, nb1;
  tpst_side_t              s1, s2, s3;

  logic signed [MP_W-1:0]  pax, pby, pbx, pay, pad, pbd, pbxd, payd;
  logic signed [ACC_W-1:0] sx3, sy3, mx3, my3;
  logic signed [CRD_W-1:0] a2, b2, nb2;
  logic signed [CRD_W-1:0] a3, b3, nb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[BACK_LAT-3:0], in_vld};
      done <= vld[BACK_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    a1  <= sat_q(side.neg_a, ovf_a, quo_a);
    b1  <= sat_q(side.neg_b, ovf_b, quo_b);
    nb1 <= sat_q(!side.neg_b, ovf_b, quo_b);
    s1  <= side;

    // m00 = m11 = a, m01 = -b, m10 = b
    pax  <= a1 * s1.ax;
    pby  <= nb1 * s1.ay;
    pbx  <= b1 * s1.ax;
    pay  <= a1 * s1.ay;
    pad  <= a1 * s1.dx;
    pbd  <= nb1 * s1.dy;
    pbxd <= b1 * s1.dx;
    payd <= a1 * s1.dy;
    a2  <= a1;
    b2  <= b1;
    nb2 <= nb1;
    s2  <= s1;

    sx3 <= {{(ACC_W - CRD_W - 16){s2.ax[CRD_W-1]}}, s2.ax, 16'b0}
         - ACC_W'(pax) - ACC_W'(pby);
    sy3 <= {{(ACC_W - CRD_W - 16){s2.ay[CRD_W-1]}}, s2.ay, 16'b0}
         - ACC_W'(pbx) - ACC_W'(pay);
    mx3 <= {{(ACC_W - CRD_W - 16){s2.ax[CRD_W-1]}}, s2.ax, 16'b0}
         + ACC_W'(pad) + ACC_W'(pbd);
    my3 <= {{(ACC_W - CRD_W - 16){s2.ay[CRD_W-1]}}, s2.ay, 16'b0}
         + ACC_W'(pbxd) + ACC_W'(payd);
    a3  <= a2;
    b3  <= b2;
    nb3 <= nb2;
    s3  <= s2;

    m00        <= s3.deg ? '0 : a3;
    m01        <= s3.deg ? '0 : nb3;
    m10        <= s3.deg ? '0 : b3;
    m11        <= s3.deg ? '0 : a3;
    shift_x    <= s3.deg ? '0 : round_sat(sx3);
    shift_y    <= s3.deg ? '0 : round_sat(sy3);
    mapped_x   <= s3.deg ? '0 : round_sat(mx3);
    mapped_y   <= s3.deg ? '0 : round_sat(my3);
    degenerate <= s3.deg;
  end

endmodule

// File: sv/two_point_similarity_transform.sv
// top level of the two point similarity transform pipeline
//
//   channel  | handshake         | payload
//   ---------+-------------------+------------------------------------------
//   input    | start, busy       | from_*, to_*, about_*, point_* (q24.8)
//   result   | done (one cycle)  | m00..m11 (q16.16), shift_*, mapped_*, degenerate
//
// one item per cycle; busy is always low
// each result passes 5 front stages, 33 divider stages (an input stage, then
// one quotient bit each) and 4 back stages
// reset clears the valid bits only; items in flight are dropped
// the receiver cannot stall, so nothing is ever held back
module two_point_similarity_transform (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tpst_pkg::CRD_W-1:0] from_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] from_y,
  input  logic signed [tpst_pkg::CRD_W-1:0] to_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] to_y,
  input  logic signed [tpst_pkg::CRD_W-1:0] about_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] about_y,
  input  logic signed [tpst_pkg::CRD_W-1:0] point_x,
  input  logic signed [tpst_pkg::CRD_W-1:0] point_y,
  output logic                              done,
  output logic signed [tpst_pkg::CRD_W-1:0] m00,
  output logic signed [tpst_pkg::CRD_W-1:0] m01,
  output logic signed [tpst_pkg::CRD_W-1:0] m10,
  output logic signed [tpst_pkg::CRD_W-1:0] m11,
  output logic signed [tpst_pkg::CRD_W-1:0] shift_x,
  output logic signed [tpst_pkg::CRD_W-1:0] shift_y,
  output logic signed [tpst_pkg::CRD_W-1:0] mapped_x,
  output logic signed [tpst_pkg::CRD_W-1:0] mapped_y,
  output logic                              degenerate
);
  import tpst_pkg::*;

  logic             front_vld;
  logic [NUM_W-1:0] num_a, num_b;
  logic [DEN_W-1:0] den;
  tpst_side_t       front_side;
  logic [QUO_W-1:0] quo_a, quo_b;
  logic             ovf_a, ovf_b;

  logic [DIV_LAT-1:0] vld_line;
  tpst_side_t         side_line [0:DIV_LAT-1];

  assign busy = 1'b0;

  tpst_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start && !busy),
    .from_x  (from_x),
    .from_y  (from_y),
    .to_x    (to_x),
    .to_y    (to_y),
    .about_x (about_x),
    .about_y (about_y),
    .point_x (point_x),
    .point_y (point_y),
    .out_vld (front_vld),
    .num_a   (num_a),
    .num_b   (num_b),
    .den     (den),
    .side    (front_side)
  );

  tpst_div u_div_a (
    .clk (clk),
    .num (num_a),
    .den (den),
    .quo (quo_a),
    .ovf (ovf_a)
  );

  tpst_div u_div_b (
    .clk (clk),
    .num (num_b),
    .den (den),
    .quo (quo_b),
    .ovf (ovf_b)
  );

  // sideband keeps pace with the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_line <= '0;
    end else begin
      vld_line <= {vld_line[DIV_LAT-2:0], front_vld};
    end
  end

  always_ff @(posedge clk) begin
    side_line[0] <= front_side;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end

  tpst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (vld_line[DIV_LAT-1]),
    .quo_a      (quo_a),
    .ovf_a      (ovf_a),
    .quo_b      (quo_b),
    .ovf_b      (ovf_b),
    .side       (side_line[DIV_LAT-1]),
    .done       (done),
    .m00        (m00),
    .m01        (m01),
    .m10        (m10),
    .m11        (m11),
    .shift_x    (shift_x),
    .shift_y    (shift_y),
    .mapped_x   (mapped_x),
    .mapped_y   (mapped_y),
    .degenerate (degenerate)
  );

`ifndef SYNTHESIS
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result without a transfer");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##TOTAL_LAT done)
    else $error("transfer lost in the pipeline");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (m00 == '0 && m10 == '0 && shift_x == '0 && mapped_y == '0))
    else $error("degenerate result not cleared");

  a_pivot_fixed_shape: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (m00 == m11))
    else $error("diagonal entries differ");
`endif

endmodule

// File: dv/tb_top.sv
// testbench for the two point similarity transform: directed and random transfers, self-checked
`timescale 1ns / 1ps

module tb_top;
  import tpst_pkg::*;

  typedef logic signed [159:0] wide_t;
  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct {
    crd_t fx, fy, tx, ty, ax, ay, px, py;
  } pts_t;

  typedef struct {
    crd_t m00, m01, m10, m11, sx, sy, qx, qy;
    logic deg;
  } xform_t;

  localparam int    LIMIT_CYCLES = 500000;
  localparam wide_t S32_MAX = 160'sd2147483647;
  localparam wide_t S32_MIN = -160'sd2147483648;

  logic clk, rst, start, busy, done, degenerate;
  crd_t from_x, from_y, to_x, to_y, about_x, about_y, point_x, point_y;
  crd_t m00, m01, m10, m11, shift_x, shift_y, mapped_x, mapped_y;

  xform_t pending_xforms[$];
  int     err_count = 0;
  int     mismatches = 0;
  int     sent_count = 0;
  int     checked_count = 0;
  int     degen_count = 0;
  int     cycle_count = 0;
  bit     no_gaps = 0;

  two_point_similarity_transform dut (
    .clk, .rst, .start, .busy,
    .from_x, .from_y, .to_x, .to_y, .about_x, .about_y, .point_x, .point_y,
    .done, .m00, .m01, .m10, .m11, .shift_x, .shift_y, .mapped_x, .mapped_y,
    .degenerate
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic crd_t sat32(wide_t a);
    if (a > S32_MAX) return crd_t'(S32_MAX);
    if (a < S32_MIN) return crd_t'(S32_MIN);
    return a[CRD_W-1:0];
  endfunction

  // round to nearest q16.16, ties away from zero
  function automatic crd_t quot_q16(wide_t n, wide_t d);
    wide_t m, q;
    m = (n < 0) ? -n : n;
    q = ((m <<< 17) + d) / (d <<< 1);
    return sat32((n < 0) ? -q : q);
  endfunction

  // q.24 down to q24.8, ties upward
  function automatic crd_t round_q8(wide_t a);
    wide_t t;
    t = a + 160'sd32768;
    return sat32(t >>> 16);
  endfunction

  function automatic xform_t similarity(pts_t p);
    wide_t vx, vy, wx, wy, dx, dy, len2, dot, crs, ax, ay;
    xform_t r;
    ax = wide_t'(p.ax);
    ay = wide_t'(p.ay);
    vx = wide_t'(p.fx) - ax;
    vy = wide_t'(p.fy) - ay;
    wx = wide_t'(p.tx) - ax;
    wy = wide_t'(p.ty) - ay;
    dx = wide_t'(p.px) - ax;
    dy = wide_t'(p.py) - ay;
    if (vx == 0 && vy == 0) begin
      r = '{default: '0};
      r.deg = 1'b1;
      return r;
    end
    len2 = vx * vx + vy * vy;
    dot  = wx * vx + wy * vy;
    crs  = wy * vx - wx * vy;
    r.m00 = quot_q16(dot, len2);
    r.m01 = quot_q16(-crs, len2);
    r.m10 = quot_q16(crs, len2);
    r.m11 = r.m00;
    r.sx = round_q8((ax <<< 16) - (wide_t'(r.m00) * ax + wide_t'(r.m01) * ay));
    r.sy = round_q8((ay <<< 16) - (wide_t'(r.m10) * ax + wide_t'(r.m11) * ay));
    r.qx = round_q8((ax <<< 16) + wide_t'(r.m00) * dx + wide_t'(r.m01) * dy);
    r.qy = round_q8((ay <<< 16) + wide_t'(r.m10) * dx + wide_t'(r.m11) * dy);
    r.deg = 1'b0;
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 60);
  endfunction

  task automatic send_points(pts_t p);
    int gap;
    start   <= 1'b1;
    from_x  <= p.fx;  from_y  <= p.fy;
    to_x    <= p.tx;  to_y    <= p.ty;
    about_x <= p.ax;  about_y <= p.ay;
    point_x <= p.px;  point_y <= p.py;
    do @(posedge clk); while (busy);
    pending_xforms.push_back(similarity(p));
    sent_count++;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (pending_xforms.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  function automatic crd_t rnd32();
    return crd_t'($urandom());
  endfunction

  function automatic crd_t rnd_near(crd_t base, int span);
    return base + crd_t'($urandom_range(0, 2 * span)) - crd_t'(span);
  endfunction

  function automatic pts_t pts(crd_t fx, fy, tx, ty, ax, ay, px, py);
    pts_t p;
    p.fx = fx; p.fy = fy; p.tx = tx; p.ty = ty;
    p.ax = ax; p.ay = ay; p.px = px; p.py = py;
    return p;
  endfunction

  task automatic test_directed();
    crd_t mx, mn;
    mx = crd_t'(S32_MAX);
    mn = crd_t'(S32_MIN);
    no_gaps = 0;
    // zero source vector, including with extreme coordinates
    send_points(pts(0, 0, 5, 7, 0, 0, 1, 1));
    send_points(pts(mx, mn, mn, mx, mx, mn, mx, mx));
    // identity, 90 degree turn, half turn, scaled turn about an offset pivot
    send_points(pts(256, 0, 256, 0, 0, 0, 512, 768));
    send_points(pts(256, 0, 0, 256, 0, 0, 512, -768));
    send_points(pts(256, 256, -256, -256, 0, 0, 100, -3));
    send_points(pts(256, 0, 512, 0, 128, 64, 1000, -1000));
    // extremes of every field
    send_points(pts(mx, mx, mx, mx, mn, mn, mx, mx));
    send_points(pts(mn, mn, mx, mx, mx, mx, mn, mn));
    send_points(pts(mx, mn, mn, mx, 0, 0, mx, mn));
    send_points(pts(mn, mx, mx, mn, -1, -1, mn, mx));
    // one lsb source vector: a huge target drives the matrix into saturation, a zero target zeroes it
    send_points(pts(1, 0, mx, mx, 0, 0, mx, mn));
    send_points(pts(0, -1, mn, mx, 0, 0, 1, 1));
    send_points(pts(mx, mx, mx - 1, mx, mx - 1, mx, mn, mn));
    // large pivot with a modest matrix pushes shift and mapped point to the rails
    send_points(pts(mx, mx - 256, mx, mx - 512, mx - 256, mx - 256, mn, mn));
    send_points(pts(mn, mn + 256, mn + 512, mn, mn + 256, mn + 256, mx, mx));
    // ratios that land on rounding ties
    send_points(pts(768, 0, 384, 0, 0, 0, 1, 1));
    send_points(pts(512, 0, 1, 1, 0, 0, 3, -3));
    send_points(pts(0, 256, 0, 0, 0, 0, 5, 5));
    send_points(pts(-2, 0, 1, 0, 0, 0, -1, 3));
    quiesce();
  endtask

  // fully random words reach every bit and the saturating paths
  task automatic test_random_wide(int n);
    for (int i = 0; i < n; i++) begin
      send_points(pts(rnd32(), rnd32(), rnd32(), rnd32(),
                      rnd32(), rnd32(), rnd32(), rnd32()));
    end
  endtask

  // points gathered round a random centre give matrices of ordinary size, rarely a zero source vector
  task automatic test_random_local(int n);
    crd_t c_x, c_y, ax, ay;
    int span;
    for (int i = 0; i < n; i++) begin
      span = ($urandom_range(0, 3) == 0) ? 4194304 : 65536;
      c_x = crd_t'($urandom_range(0, 2 * 8388608)) - crd_t'(8388608);
      c_y = crd_t'($urandom_range(0, 2 * 8388608)) - crd_t'(8388608);
      ax = rnd_near(c_x, span);
      ay = rnd_near(c_y, span);
      if ($urandom_range(0, 24) == 0)
        send_points(pts(ax, ay, rnd_near(c_x, span), rnd_near(c_y, span),
                        ax, ay, rnd_near(c_x, span), rnd_near(c_y, span)));
      else
        send_points(pts(rnd_near(c_x, span), rnd_near(c_y, span),
                        rnd_near(c_x, span), rnd_near(c_y, span),
                        ax, ay, rnd_near(c_x, span), rnd_near(c_y, span)));
    end
  endtask

  // source almost on the pivot: tiny divisors, often saturated entries
  task automatic test_near_degenerate(int n);
    crd_t ax, ay;
    for (int i = 0; i < n; i++) begin
      ax = rnd32();
      ay = rnd32();
      send_points(pts(rnd_near(ax, 3), rnd_near(ay, 3),
                      rnd_near(ax, 4096), rnd_near(ay, 4096),
                      ax, ay, rnd_near(ax, 65536), rnd_near(ay, 65536)));
    end
  endtask

  // every cycle a transfer, to fill the pipeline end to end
  task automatic test_back_to_back(int n);
    no_gaps = 1;
    test_random_local(n);
    no_gaps = 0;
  endtask

  always @(posedge clk) begin
    xform_t e;
    if (!rst && done) begin
      if (pending_xforms.size() == 0) begin
        err_count++;
        $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        e = pending_xforms.pop_front();
        checked_count++;
        if (e.deg) degen_count++;
        if ({m00, m01, m10, m11, shift_x, shift_y, mapped_x, mapped_y, degenerate} !==
            {e.m00, e.m01, e.m10, e.m11, e.sx, e.sy, e.qx, e.qy, e.deg}) begin
          err_count++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d:", checked_count);
            $display("  m00 %h/%h m01 %h/%h m10 %h/%h m11 %h/%h (exp/got)",
                     e.m00, m00, e.m01, m01, e.m10, m10, e.m11, m11);
            $display("  shift %h,%h/%h,%h mapped %h,%h/%h,%h degenerate %b/%b",
                     e.sx, e.sy, shift_x, shift_y, e.qx, e.qy, mapped_x, mapped_y,
                     e.deg, degenerate);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", pending_xforms.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    {from_x, from_y, to_x, to_y, about_x, about_y, point_x, point_y} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_wide(200);
    test_random_local(250);
    quiesce();
    test_near_degenerate(150);
    test_back_to_back(230);
    quiesce();

    if (pending_xforms.size() != 0) err_count += pending_xforms.size();
    $display("sent %0d transfers, checked %0d results (%0d with a zero source vector)",
             sent_count, checked_count, degen_count);
    $display("covered extremes, rounding ties, saturation, near-zero divisors, full-rate bursts");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/tpst_pkg.sv
sv/tpst_front.sv
sv/tpst_div.sv
sv/tpst_back.sv
sv/two_point_similarity_transform.sv
dv/tb_top.sv
